// ===== hdl/apts_pkg.sv =====
// Shared types, codes and helpers for the actuator pulse-train sequencer.
// No dependencies; the register file, the core and the top level import this package.
package apts_pkg;

	// Configuration port geometry
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W  = 3;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_STRONG = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_WEAK   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEATS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 3'd4;

	// Register reset values
	localparam logic [15:0] HIGH_TIME_RST = 16'd1;
	localparam logic [15:0] REPEATS_RST   = 16'd1;
	localparam logic [15:0] COOLDOWN_RST  = 16'd1;
	localparam logic [9:0]  THRESHOLD_RST = 10'd395;

	// Operation codes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_SLEEP = 2'd1;
	localparam logic [1:0] OP_TEST  = 2'd2;

	// Pulse phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HIGH = 2'd1;
	localparam logic [1:0] PH_LOW  = 2'd2;

	// Test sequence steps
	localparam logic [1:0] TS_COOLDOWN = 2'd0;
	localparam logic [1:0] TS_RUN      = 2'd1;
	localparam logic [1:0] TS_DONE     = 2'd2;

	// Default limits
	localparam logic [7:0] HIGH_TIME_LIMIT_DEF = 8'd40;
	localparam logic [7:0] TEST_RUNS_DEF       = 8'd1;

	typedef struct packed {
		logic [15:0] high_strong;
		logic [15:0] high_weak;
		logic [15:0] repeats;
		logic [15:0] cooldown;
		logic [9:0]  threshold;
	} cfg_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] signal_value;
		logic       supply_normal;
		logic [9:0] battery_level;
	} item_t;

	typedef struct packed {
		logic       drive_enable;
		logic [1:0] pulse_phase;
		logic       test_active;
	} result_t;

	// Clamp a raw high time to 1..lim
	function automatic logic [7:0] clamp_high(logic [15:0] v, logic [7:0] lim);
		if (v == 16'd0) begin
			return 8'd1;
		end else if (v > {8'd0, lim}) begin
			return lim;
		end else begin
			return v[7:0];
		end
	endfunction

endpackage

// ===== hdl/apts_in_if.sv =====
// Input channel of the pulse-train sequencer: valid/ready plus one input item.
// No dependencies.
interface apts_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] signal_value;
	logic       supply_normal;
	logic [9:0] battery_level;

	modport source (output valid, output operation, output signal_value,
		output supply_normal, output battery_level, input ready);
	modport sink (input valid, input operation, input signal_value,
		input supply_normal, input battery_level, output ready);
endinterface

// ===== hdl/apts_out_if.sv =====
// Result channel of the pulse-train sequencer: valid/ready plus one result item.
// No dependencies.
interface apts_out_if;
	logic       valid;
	logic       ready;
	logic       drive_enable;
	logic [1:0] pulse_phase;
	logic       test_active;

	modport source (output valid, output drive_enable, output pulse_phase,
		output test_active, input ready);
	modport sink (input valid, input drive_enable, input pulse_phase,
		input test_active, output ready);
endinterface

// ===== hdl/apts_cfg_regs.sv =====
// Configuration register file of the pulse-train sequencer.
// Depends on apts_pkg.
module apts_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [apts_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [apts_pkg::CFG_DATA_W-1:0]      cfg_data,
	output apts_pkg::cfg_t                       cfg
);
	import apts_pkg::*;

	cfg_t cfg_q;

	// Write the addressed register; drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_strong <= HIGH_TIME_RST;
			cfg_q.high_weak   <= HIGH_TIME_RST;
			cfg_q.repeats     <= REPEATS_RST;
			cfg_q.cooldown    <= COOLDOWN_RST;
			cfg_q.threshold   <= THRESHOLD_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_HIGH_STRONG: cfg_q.high_strong <= cfg_data;
				REG_HIGH_WEAK:   cfg_q.high_weak   <= cfg_data;
				REG_REPEATS:     cfg_q.repeats     <= cfg_data;
				REG_COOLDOWN:    cfg_q.cooldown    <= cfg_data;
				REG_THRESHOLD:   cfg_q.threshold   <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// ===== hdl/apts_core.sv =====
// Sequencer state and its next-state logic: pulse train, test run, abort.
// Depends on apts_pkg; the result is the state after the current item.
module apts_core #(
	parameter logic [7:0] HIGH_TIME_LIMIT = apts_pkg::HIGH_TIME_LIMIT_DEF,
	parameter logic [7:0] TEST_RUNS       = apts_pkg::TEST_RUNS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  apts_pkg::item_t   item,
	input  apts_pkg::cfg_t    cfg,
	output apts_pkg::result_t result
);
	import apts_pkg::*;

	logic [1:0]  phase_q, phase_d;
	logic [15:0] phase_timer_q, phase_timer_d;
	logic [7:0]  repeats_left_q, repeats_left_d;
	logic [7:0]  prev_signal_q, prev_signal_d;
	logic        drive_q, drive_d;
	logic        test_mode_q, test_mode_d;
	logic [1:0]  test_step_q, test_step_d;
	logic [7:0]  test_ticks_q, test_ticks_d;
	logic [7:0]  test_runs_q, test_runs_d;
	logic [7:0]  lat_strong_q, lat_strong_d;
	logic [7:0]  lat_weak_q, lat_weak_d;
	logic [15:0] lat_cool_q, lat_cool_d;

	logic [7:0]  tick_inc;
	logic [7:0]  runs_inc;
	logic [15:0] timer_dec;
	logic [7:0]  repeats_dec;
	logic [7:0]  strong_clamp;
	logic [7:0]  weak_clamp;
	logic        battery_weak;

	// Compute the state after this item
	always_comb begin
		phase_d        = phase_q;
		phase_timer_d  = phase_timer_q;
		repeats_left_d = repeats_left_q;
		prev_signal_d  = prev_signal_q;
		drive_d        = drive_q;
		test_mode_d    = test_mode_q;
		test_step_d    = test_step_q;
		test_ticks_d   = test_ticks_q;
		test_runs_d    = test_runs_q;
		lat_strong_d   = lat_strong_q;
		lat_weak_d     = lat_weak_q;
		lat_cool_d     = lat_cool_q;

		tick_inc     = test_ticks_q + 8'd1;
		runs_inc     = test_runs_q + 8'd1;
		timer_dec    = phase_timer_q - 16'd1;
		repeats_dec  = repeats_left_q - 8'd1;
		strong_clamp = clamp_high(cfg.high_strong, HIGH_TIME_LIMIT);
		weak_clamp   = clamp_high(cfg.high_weak, HIGH_TIME_LIMIT);
		battery_weak = (item.battery_level < cfg.threshold);

		case (item.operation)
			OP_TICK: begin
				if (item.supply_normal) begin
					if (test_mode_q) begin
						// Test run holds the train idle
						phase_d = PH_IDLE;
						case (test_step_q)
							TS_COOLDOWN: begin
								drive_d      = 1'b0;
								test_ticks_d = tick_inc;
								if ({8'd0, tick_inc} >= cfg.cooldown) begin
									test_ticks_d = 8'd0;
									test_step_d  = TS_RUN;
								end
							end
							TS_RUN: begin
								drive_d      = 1'b1;
								test_ticks_d = tick_inc;
								if (tick_inc >= cfg.high_strong[7:0]) begin
									test_runs_d  = runs_inc;
									test_ticks_d = 8'd0;
									test_step_d  = (runs_inc >= TEST_RUNS) ? TS_DONE : TS_COOLDOWN;
								end
							end
							TS_DONE: begin
								test_mode_d  = 1'b0;
								test_step_d  = TS_RUN;
								test_runs_d  = 8'd0;
								test_ticks_d = 8'd0;
								drive_d      = 1'b0;
							end
							default: ;
						endcase
					end else if (phase_q == PH_IDLE) begin
						// Start a train on a rising edge from zero to one
						if (item.signal_value == 8'd1 && prev_signal_q == 8'd0) begin
							phase_d        = PH_HIGH;
							lat_strong_d   = strong_clamp;
							lat_weak_d     = weak_clamp;
							lat_cool_d     = (cfg.cooldown == 16'd0) ? 16'd1 : cfg.cooldown;
							repeats_left_d = (cfg.repeats == 16'd0) ? 8'd1 : cfg.repeats[7:0];
							phase_timer_d  = {8'd0, battery_weak ? weak_clamp : strong_clamp};
							drive_d        = 1'b1;
						end
					end else if (phase_q == PH_HIGH) begin
						phase_timer_d = timer_dec;
						if (timer_dec == 16'd0) begin
							phase_d       = PH_LOW;
							drive_d       = 1'b0;
							phase_timer_d = lat_cool_q;
						end
					end else if (phase_q == PH_LOW) begin
						phase_timer_d = timer_dec;
						if (timer_dec == 16'd0) begin
							repeats_left_d = repeats_dec;
							if (repeats_dec == 8'd0) begin
								phase_d = PH_IDLE;
							end else begin
								phase_d       = PH_HIGH;
								phase_timer_d = {8'd0, battery_weak ? lat_weak_q : lat_strong_q};
								drive_d       = 1'b1;
							end
						end
					end
				end else begin
					// Abnormal supply aborts train and test
					phase_d     = PH_IDLE;
					test_step_d = TS_DONE;
					drive_d     = 1'b0;
				end
				prev_signal_d = item.signal_value;
			end
			OP_SLEEP: begin
				phase_d       = PH_IDLE;
				test_step_d   = TS_DONE;
				drive_d       = 1'b0;
				prev_signal_d = 8'd0;
			end
			OP_TEST: begin
				test_mode_d = 1'b1;
			end
			default: ;
		endcase
	end

	// Commit the new state when the item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			phase_timer_q  <= 16'd0;
			repeats_left_q <= 8'd0;
			prev_signal_q  <= 8'd0;
			drive_q        <= 1'b0;
			test_mode_q    <= 1'b0;
			test_step_q    <= TS_RUN;
			test_ticks_q   <= 8'd0;
			test_runs_q    <= 8'd0;
			lat_strong_q   <= 8'd1;
			lat_weak_q     <= 8'd1;
			lat_cool_q     <= 16'd1;
		end else if (advance) begin
			phase_q        <= phase_d;
			phase_timer_q  <= phase_timer_d;
			repeats_left_q <= repeats_left_d;
			prev_signal_q  <= prev_signal_d;
			drive_q        <= drive_d;
			test_mode_q    <= test_mode_d;
			test_step_q    <= test_step_d;
			test_ticks_q   <= test_ticks_d;
			test_runs_q    <= test_runs_d;
			lat_strong_q   <= lat_strong_d;
			lat_weak_q     <= lat_weak_d;
			lat_cool_q     <= lat_cool_d;
		end
	end

	assign result.drive_enable = drive_d;
	assign result.pulse_phase  = phase_d;
	assign result.test_active  = test_mode_d;
endmodule

// ===== hdl/actuator_pulse_train_sequencer_unit.sv =====
// Actuator pulse-train sequencer, top level. Takes one item per clock cycle
// while the result side does not stall, and returns one result per item:
// the item lands in an input register, the sequencer state logic works on
// it combinationally, and the result waits in an output register. The input
// side keeps taking items while a result waits, stalling only when both
// registers are full. Configuration writes take effect on the next cycle and
// should be made while no item is in flight. Depends on apts_pkg, apts_in_if,
// apts_out_if, apts_cfg_regs and apts_core.
module actuator_pulse_train_sequencer_unit #(
	parameter logic [7:0] HIGH_TIME_LIMIT = apts_pkg::HIGH_TIME_LIMIT_DEF,
	parameter logic [7:0] TEST_RUNS       = apts_pkg::TEST_RUNS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	apts_in_if.sink                         item,
	apts_out_if.source                      result,
	input  logic                            cfg_wr_en,
	input  logic [apts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [apts_pkg::CFG_DATA_W-1:0] cfg_data
);
	import apts_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_next;
	result_t result_s2;
	logic    valid_s2;
	logic    advance;
	logic    in_xfer;

	// Move the held item on when the result register is free or being drained
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign in_xfer    = item.valid && item.ready;

	apts_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	apts_core #(
		.HIGH_TIME_LIMIT (HIGH_TIME_LIMIT),
		.TEST_RUNS       (TEST_RUNS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (res_next)
	);

	// Track occupancy of the input and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_xfer) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (result.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Capture payloads
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.operation     <= item.operation;
			item_s1.signal_value  <= item.signal_value;
			item_s1.supply_normal <= item.supply_normal;
			item_s1.battery_level <= item.battery_level;
		end
		if (advance) begin
			result_s2 <= res_next;
		end
	end

	assign result.valid        = valid_s2;
	assign result.drive_enable = result_s2.drive_enable;
	assign result.pulse_phase  = result_s2.pulse_phase;
	assign result.test_active  = result_s2.test_active;
endmodule
